// ===== rtl/core/sve_pkg.sv =====
// shared types and constants for the vertical sobel edge filter
// no dependencies; imported by sve_scan, sve_grad and the top level
`timescale 1ns / 1ps

package sve_pkg;

    localparam int PIXEL_W           = 8;
    localparam int COL_OUT_W         = 10;
    localparam int ROW_W             = 16;
    localparam int IMAGE_WIDTH_W     = 11;
    localparam int IMAGE_HEIGHT_W    = 16;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_INDEX_W       = 1;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MIN_SIZE          = 3;
    localparam int WIDTH_RESET       = 512;
    localparam int HEIGHT_RESET      = 512;
    localparam int SUM_W             = PIXEL_W + 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // position information for one accepted pixel
    typedef struct packed {
        logic                 emit;
        logic                 frame_end;
        logic [COL_OUT_W-1:0] column;
        logic [ROW_W-1:0]     row;
    } scan_info_t;

endpackage

// ===== rtl/core/sve_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sve_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sve_scan.sv =====
// configuration registers and raster position counters
// depends on sve_pkg
`timescale 1ns / 1ps

module sve_scan #(
    parameter int MAX_WIDTH = sve_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sve_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sve_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           accept,
    output logic [$clog2(MAX_WIDTH)-1:0]   addr,
    output sve_pkg::scan_info_t            info
);

    import sve_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int LIM_W  = (IMAGE_WIDTH_W > ADDR_W + 1) ? IMAGE_WIDTH_W : ADDR_W + 1;
    localparam int OC_W   = (ADDR_W > COL_OUT_W) ? ADDR_W : COL_OUT_W;

    logic [IMAGE_WIDTH_W-1:0]  width_reg;
    logic [IMAGE_HEIGHT_W-1:0] height_reg;
    logic [ADDR_W-1:0]         col_reg;
    logic [ADDR_W-1:0]         col_next;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;
    logic [LIM_W-1:0]          width_ext;
    logic [LIM_W-1:0]          last_col;
    logic [ROW_W-1:0]          last_row;
    logic [OC_W-1:0]           col_m1;
    logic                      row_end;
    logic                      frame_end;

    // effective limits: width clamped to MIN_SIZE..MAX_WIDTH, height to MIN_SIZE and up
    always_comb
    begin
        width_ext = LIM_W'(width_reg);
        if (width_ext < LIM_W'(MIN_SIZE))
        begin
            last_col = LIM_W'(MIN_SIZE - 1);
        end
        else if (width_ext > LIM_W'(MAX_WIDTH))
        begin
            last_col = LIM_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = width_ext - LIM_W'(1);
        end

        if (height_reg < ROW_W'(MIN_SIZE))
        begin
            last_row = ROW_W'(MIN_SIZE - 1);
        end
        else
        begin
            last_row = height_reg - ROW_W'(1);
        end
    end

    assign row_end   = (LIM_W'(col_reg) >= last_col);
    assign frame_end = row_end && (row_reg >= last_row);
    assign col_m1    = OC_W'(col_reg) - OC_W'(1);

    assign addr           = col_reg;
    assign info.emit      = (col_reg >= ADDR_W'(2)) && (row_reg >= ROW_W'(2));
    assign info.frame_end = frame_end;
    assign info.column    = col_m1[COL_OUT_W-1:0];
    assign info.row       = row_reg - ROW_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_W'(WIDTH_RESET);
            height_reg <= IMAGE_HEIGHT_W'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMAGE_WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMAGE_HEIGHT_W-1:0];
                    default:          width_reg  <= width_reg;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= ADDR_W'(MAX_WIDTH - 1))
        else $error("column counter beyond line buffer depth");

    a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && row_end |=> col_reg == '0)
        else $error("column counter did not wrap at row end");

    a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !row_end |=> col_reg == ADDR_W'($past(col_reg) + ADDR_W'(1)))
        else $error("column counter did not advance by one");
`endif

endmodule

// ===== rtl/core/sve_grad.sv =====
// window stage, vertical gradient with clamp, and output register
// depends on sve_pkg; takes line buffer read data from two sve_ram instances
`timescale 1ns / 1ps

module sve_grad #(
    parameter int MAX_WIDTH = sve_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sve_pkg::PIXEL_W-1:0]       pixel_in,
    input  logic [$clog2(MAX_WIDTH)-1:0]      addr_in,
    input  sve_pkg::scan_info_t               info_in,
    input  logic [sve_pkg::PIXEL_W-1:0]       top_pix,
    input  logic [sve_pkg::PIXEL_W-1:0]       mid_pix,
    output logic                              upper_we,
    output logic [$clog2(MAX_WIDTH)-1:0]      upper_waddr,
    output logic [sve_pkg::PIXEL_W-1:0]       upper_wdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sve_pkg::PIXEL_W-1:0]       edge_value,
    output logic [sve_pkg::COL_OUT_W-1:0]     out_column,
    output logic [sve_pkg::ROW_W-1:0]         out_row,
    output logic                              frame_last
);

    import sve_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    scan_info_t           s1_info_reg;
    logic [PIXEL_W-1:0]   s1_pix_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [PIXEL_W-1:0]   top0_reg;
    logic [PIXEL_W-1:0]   top1_reg;
    logic [PIXEL_W-1:0]   bot0_reg;
    logic [PIXEL_W-1:0]   bot1_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [PIXEL_W-1:0]   edge_reg;
    logic [COL_OUT_W-1:0] column_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 last_reg;
    logic                 accept;
    logic                 s1_adv;
    logic [SUM_W-1:0]     upp_sum;
    logic [SUM_W-1:0]     bot_sum;
    logic [SUM_W:0]       diff;
    logic [PIXEL_W-1:0]   clamped;

    // stage 1 leaves when its result has a free slot, or it has no result
    assign s1_adv   = s1_valid_reg && (!s1_info_reg.emit || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // the row above gets the old middle row value once the read data is back
    assign upper_we    = s1_adv;
    assign upper_waddr = s1_addr_reg;
    assign upper_wdata = mid_pix;

    // window after the shift: newest column is (top_pix, s1_pix_reg)
    assign upp_sum = SUM_W'(top0_reg) + {1'b0, top1_reg, 1'b0} + SUM_W'(top_pix);
    assign bot_sum = SUM_W'(bot0_reg) + {1'b0, bot1_reg, 1'b0} + SUM_W'(s1_pix_reg);
    assign diff    = {1'b0, bot_sum} - {1'b0, upp_sum};

    always_comb
    begin
        if (diff[SUM_W])
        begin
            clamped = '0;
        end
        else if (diff[SUM_W-1:PIXEL_W] != '0)
        begin
            clamped = '1;
        end
        else
        begin
            clamped = diff[PIXEL_W-1:0];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_info_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            top0_reg      <= '0;
            top1_reg      <= '0;
            bot0_reg      <= '0;
            bot1_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                top0_reg <= top1_reg;
                top1_reg <= top_pix;
                bot0_reg <= bot1_reg;
                bot1_reg <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info_in;
            s1_pix_reg  <= pixel_in;
            s1_addr_reg <= addr_in;
        end
        if (s1_adv && s1_info_reg.emit)
        begin
            edge_reg   <= clamped;
            column_reg <= s1_info_reg.column;
            row_reg    <= s1_info_reg.row;
            last_reg   <= s1_info_reg.frame_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_value = edge_reg;
    assign out_column = column_reg;
    assign out_row    = row_reg;
    assign frame_last = last_reg;

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach stage 1");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_info_reg.emit && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked result");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_info_reg.emit |=> out_valid_reg)
        else $error("emitted result not held in output register");
`endif

endmodule

// ===== rtl/core/sobel_vertical_edge_filter.sv =====
// top level of the streaming vertical sobel edge filter
// depends on sve_pkg, sve_scan, sve_ram and sve_grad
`timescale 1ns / 1ps

// usage
// - input channel in_valid / in_ready / pixel_in carries one 8-bit grey pixel per
//   transaction, in raster order, row after row, frame after frame
// - output channel out_valid / out_ready carries one result transaction per interior
//   pixel: edge_value (bottom row 1,2,1 minus top row 1,2,1, clamped to 0..255),
//   out_column, out_row and frame_last on the final interior pixel of a frame
// - border pixels produce no transaction; the result for pixel (r-1, c-1) leaves
//   when the pixel at (r, c) has been taken
// - the completing pixel is registered in stage 1, its result in the output register
// - throughput: one pixel per clock while in_ready is high, set by the single read and
//   write port of each line buffer ram (read at accept, registered, used in stage 1)
// - a stalled receiver holds the result in the output register; pixels that
//   complete no result keep passing the window stage, the next one that does
//   waits there and in_ready drops until out_ready returns
// - configuration: cfg_we writes cfg_data into image_width or image_height,
//   chosen by cfg_index; writing only while the block is idle is up to the user
// - reset: counters and window clear, width and height return to 512; the line
//   buffers are not cleared and need no clearing pass, since rows 0 and 1 of a
//   frame write every entry a result uses, and earlier reads feed border pixels only

module sobel_vertical_edge_filter #(
    parameter int MAX_WIDTH = sve_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sve_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sve_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sve_pkg::PIXEL_W-1:0]     pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sve_pkg::PIXEL_W-1:0]     edge_value,
    output logic [sve_pkg::COL_OUT_W-1:0]   out_column,
    output logic [sve_pkg::ROW_W-1:0]       out_row,
    output logic                            frame_last
);

    import sve_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic                accept;
    logic [ADDR_W-1:0]   addr;
    scan_info_t          info;
    logic [PIXEL_W-1:0]  top_pix;
    logic [PIXEL_W-1:0]  mid_pix;
    logic                upper_we;
    logic [ADDR_W-1:0]   upper_waddr;
    logic [PIXEL_W-1:0]  upper_wdata;

    // a pixel transaction completes on valid and ready together
    assign accept = in_valid && in_ready;

    // position counters and configuration registers
    sve_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .addr      (addr),
        .info      (info)
    );

    // row before last: written when stage 1 advances, with the old last-row value
    sve_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (MAX_WIDTH)
    ) u_upper_buf (
        .clk   (clk),
        .we    (upper_we),
        .waddr (upper_waddr),
        .wdata (upper_wdata),
        .re    (accept),
        .raddr (addr),
        .rdata (top_pix)
    );

    // last row: the new pixel replaces the entry read in the same cycle
    sve_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (MAX_WIDTH)
    ) u_lower_buf (
        .clk   (clk),
        .we    (accept),
        .waddr (addr),
        .wdata (pixel_in),
        .re    (accept),
        .raddr (addr),
        .rdata (mid_pix)
    );

    // window, gradient, clamp and output register
    sve_grad #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_grad (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .addr_in     (addr),
        .info_in     (info),
        .top_pix     (top_pix),
        .mid_pix     (mid_pix),
        .upper_we    (upper_we),
        .upper_waddr (upper_waddr),
        .upper_wdata (upper_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .edge_value  (edge_value),
        .out_column  (out_column),
        .out_row     (out_row),
        .frame_last  (frame_last)
    );

endmodule
